@@ sv/w2s_pkg.sv @@
// Shared types, constants and the saturation helper function of the world-to-screen projection block.
package w2s_pkg;

  localparam int ACC_W   = 64;
  localparam int COORD_W = 32;
  localparam int HALF_W  = 13;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CAPTURE,
    DP_MUL,
    DP_ACC,
    DP_ADDC,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_DIV_END,
    DP_MAP_XM,
    DP_MAP_XA,
    DP_MAP_YM,
    DP_MAP_YA,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] idx;
    logic [1:0] k;
  } dp_cmd_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [COORD_W-1:0] res;
    if (v > ACC_W'(COORD_MAX)) begin
      res = COORD_MAX;
    end else if (v < ACC_W'(COORD_MIN)) begin
      res = COORD_MIN;
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ sv/world_to_screen_projection.sv @@
// Top level of the world-to-screen projection block.
// Each input request either loads one coefficient of a 4x4 row-vector matrix
// (tuser = 0) or projects a point (tuser = 1). A load writes the coefficient
// store in the cycle it is accepted and produces no result. A projection
// multiplies (x, y, z, 1) by the matrix, divides x, y and z by w and maps the
// normalized x and y to pixel coordinates using half the configured screen
// width and height; all values are signed fixed point.
// A projection occupies the block for the accepting cycle, twelve products on
// one shared 32x32 multiplier (a multiply and an accumulate step each), four
// constant-row adds, three restoring divisions by w (an init step, one step per
// quotient bit and an end step each), four viewport steps and one output step.
// The next request can be accepted from the cycle in which out_tvalid rises.
// Most of a projection's time is spent in the divider loop.
// The result is held in an output register, so a new request is accepted
// while a finished result still waits; if the receiver stalls, the next
// projection waits at its end until the register is free.
// Synchronous reset clears the coefficient store to zero, sets width 1280
// and height 720, and drops out_tvalid. Configuration must be written only
// while the block is idle; the block itself does not enforce this.
module world_to_screen_projection #(
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata fields from bit 0: coeff_index[3:0], coeff_value[35:4], pos_x[67:36],
  // pos_y[99:68], pos_z[131:100], zero padding[135:132].
  input  logic [135:0] in_tdata,
  // tuser fields from bit 0: operation.
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata fields from bit 0: screen_x[31:0], screen_y[63:32], depth[95:64].
  output logic [95:0]  out_tdata,
  // tuser fields from bit 0: visible, w_zero.
  output logic [1:0]   out_tuser,
  input  logic         cfg_wr_en,
  input  logic [0:0]   cfg_addr,
  input  logic [13:0]  cfg_wr_data
);

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  logic [13:0]      width_r, height_r;
  w2s_pkg::dp_cmd_t cmd;
  logic signed [31:0] scx, scy, dep;
  logic             vis, wz;

  // Screen size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 14'd1280;
      height_r <= 14'd720;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_WIDTH:  width_r  <= cfg_wr_data;
        REG_HEIGHT: height_r <= cfg_wr_data;
        default: begin
        end
      endcase
    end
  end

  w2s_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser[0]),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd)
  );

  w2s_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .coeff_index (in_tdata[3:0]),
    .coeff_value (in_tdata[35:4]),
    .pos_x       (in_tdata[67:36]),
    .pos_y       (in_tdata[99:68]),
    .pos_z       (in_tdata[131:100]),
    .half_w      (width_r[13:1]),
    .half_h      (height_r[13:1]),
    .screen_x    (scx),
    .screen_y    (scy),
    .depth       (dep),
    .visible     (vis),
    .w_zero      (wz)
  );

  assign out_tdata = {dep, scy, scx};
  assign out_tuser = {wz, vis};

endmodule

@@ sv/w2s_datapath.sv @@
// Datapath: coefficient store, shared multiplier, accumulators, divider and output registers.
module w2s_datapath #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  w2s_pkg::dp_cmd_t                    cmd,
  input  logic [3:0]                          coeff_index,
  input  logic signed [w2s_pkg::COORD_W-1:0]  coeff_value,
  input  logic signed [w2s_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [w2s_pkg::COORD_W-1:0]  pos_y,
  input  logic signed [w2s_pkg::COORD_W-1:0]  pos_z,
  input  logic [w2s_pkg::HALF_W-1:0]          half_w,
  input  logic [w2s_pkg::HALF_W-1:0]          half_h,
  output logic signed [w2s_pkg::COORD_W-1:0]  screen_x,
  output logic signed [w2s_pkg::COORD_W-1:0]  screen_y,
  output logic signed [w2s_pkg::COORD_W-1:0]  depth,
  output logic                                visible,
  output logic                                w_zero
);

  localparam int AW    = w2s_pkg::ACC_W;
  localparam int CW    = w2s_pkg::COORD_W;
  localparam int NUM_W = AW + FRACTION_BITS;
  localparam logic signed [CW-1:0] ONE = CW'(64'sd1 <<< FRACTION_BITS);

  logic signed [CW-1:0] coef_r [16];
  logic signed [CW-1:0] pos_r  [3];
  logic signed [AW-1:0] acc_r  [4];
  logic signed [CW-1:0] ndc_r  [3];
  logic signed [AW-1:0] prod_r;
  logic [AW-1:0]        rem_r;
  logic [CW-1:0]        numlo_r;
  logic [CW-1:0]        q_r;
  logic                 ovf_r;
  logic signed [CW-1:0] mapx_r, mapy_r;
  logic signed [CW-1:0] scx_r, scy_r, depth_r;
  logic                 vis_r, wz_r;

  logic signed [CW-1:0] mul_a, mul_b;
  logic signed [AW-1:0] t_sel, w_val;
  logic [AW-1:0]        a_abs, d_abs;
  logic [NUM_W-1:0]     num;
  logic [AW-1:0]        hi_ext;
  logic [AW:0]          rem2;
  logic                 ge;
  logic [AW:0]          rem_sub;
  logic                 neg, wz;
  logic signed [CW-1:0] div_res;
  logic signed [AW-1:0] hw_shift, hh_shift;

  always_comb begin
    case (cmd.op)
      w2s_pkg::DP_MAP_XM: begin
        mul_a = ndc_r[0];
        mul_b = CW'(half_w);
      end
      w2s_pkg::DP_MAP_YM: begin
        mul_a = ndc_r[1];
        mul_b = CW'(half_h);
      end
      default: begin
        case (cmd.idx[3:2])
          2'd0:    mul_a = pos_r[0];
          2'd1:    mul_a = pos_r[1];
          default: mul_a = pos_r[2];
        endcase
        mul_b = coef_r[cmd.idx];
      end
    endcase
  end

  assign t_sel  = acc_r[cmd.k];
  assign w_val  = acc_r[3];
  assign wz     = (w_val == '0);
  assign a_abs  = t_sel[AW-1] ? AW'(-t_sel) : AW'(t_sel);
  assign d_abs  = w_val[AW-1] ? AW'(-w_val) : AW'(w_val);
  assign num    = NUM_W'(a_abs) << FRACTION_BITS;
  assign hi_ext = AW'(num[NUM_W-1:CW]);
  assign rem2   = {rem_r, numlo_r[CW-1]};
  assign ge     = rem2 >= {1'b0, d_abs};
  assign rem_sub = rem2 - {1'b0, d_abs};
  assign neg    = t_sel[AW-1] ^ w_val[AW-1];
  assign hw_shift = AW'(half_w) <<< FRACTION_BITS;
  assign hh_shift = AW'(half_h) <<< FRACTION_BITS;

  // Sign, zero-w and overflow handling of one quotient.
  always_comb begin
    if (wz) begin
      div_res = t_sel[AW-1] ? w2s_pkg::COORD_MIN : w2s_pkg::COORD_MAX;
    end else if (ovf_r) begin
      div_res = neg ? w2s_pkg::COORD_MIN : w2s_pkg::COORD_MAX;
    end else if (neg) begin
      div_res = (q_r > 32'h8000_0000) ? w2s_pkg::COORD_MIN : CW'(-q_r);
    end else begin
      div_res = q_r[CW-1] ? w2s_pkg::COORD_MAX : CW'(q_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cmd.op == w2s_pkg::DP_LOAD) begin
      coef_r[coeff_index] <= coeff_value;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      w2s_pkg::DP_CAPTURE: begin
        pos_r[0] <= pos_x;
        pos_r[1] <= pos_y;
        pos_r[2] <= pos_z;
        for (int i = 0; i < 4; i++) begin
          acc_r[i] <= '0;
        end
      end
      w2s_pkg::DP_MUL: begin
        prod_r <= mul_a * mul_b;
      end
      w2s_pkg::DP_ACC: begin
        acc_r[cmd.idx[1:0]] <= acc_r[cmd.idx[1:0]] + (prod_r >>> FRACTION_BITS);
      end
      w2s_pkg::DP_ADDC: begin
        acc_r[cmd.idx[1:0]] <= acc_r[cmd.idx[1:0]] + AW'(coef_r[cmd.idx]);
      end
      w2s_pkg::DP_DIV_INIT: begin
        // A quotient of 2^32 or more saturates, so only 32 bits are developed.
        ovf_r   <= hi_ext >= d_abs;
        rem_r   <= hi_ext;
        numlo_r <= num[CW-1:0];
        q_r     <= '0;
      end
      w2s_pkg::DP_DIV_STEP: begin
        rem_r   <= ge ? rem_sub[AW-1:0] : rem2[AW-1:0];
        numlo_r <= {numlo_r[CW-2:0], 1'b0};
        q_r     <= {q_r[CW-2:0], ge};
      end
      w2s_pkg::DP_DIV_END: begin
        case (cmd.k)
          2'd0:    ndc_r[0] <= div_res;
          2'd1:    ndc_r[1] <= div_res;
          default: ndc_r[2] <= div_res;
        endcase
      end
      w2s_pkg::DP_MAP_XM, w2s_pkg::DP_MAP_YM: begin
        prod_r <= mul_a * mul_b;
      end
      w2s_pkg::DP_MAP_XA: begin
        mapx_r <= w2s_pkg::sat32(prod_r + hw_shift);
      end
      w2s_pkg::DP_MAP_YA: begin
        mapy_r <= w2s_pkg::sat32(hh_shift - prod_r);
      end
      w2s_pkg::DP_EMIT: begin
        // The output registers change only here, so a waiting result holds.
        scx_r   <= mapx_r;
        scy_r   <= mapy_r;
        depth_r <= ndc_r[2];
        wz_r    <= wz;
        vis_r   <= !wz && (ndc_r[0] <= ONE) && (ndc_r[0] >= -ONE) &&
                   (ndc_r[1] <= ONE) && (ndc_r[1] >= -ONE) && (ndc_r[2] >= 0);
      end
      default: begin
      end
    endcase
  end

  assign screen_x = scx_r;
  assign screen_y = scy_r;
  assign depth    = depth_r;
  assign visible  = vis_r;
  assign w_zero   = wz_r;

endmodule

@@ sv/w2s_ctrl.sv @@
// Controller state machine that sequences the datapath for each request.
module w2s_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output w2s_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_END,
    ST_MAP_XM,
    ST_MAP_XA,
    ST_MAP_YM,
    ST_MAP_YA,
    ST_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = w2s_pkg::DP_NOP;
    cmd.idx       = idx_r;
    cmd.k         = k_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op) begin
            cmd.op    = w2s_pkg::DP_CAPTURE;
            idx_nxt   = '0;
            state_nxt = ST_MUL;
          end else begin
            cmd.op = w2s_pkg::DP_LOAD;
          end
        end
      end
      ST_MUL: begin
        if (idx_r[3:2] == 2'd3) begin
          // Constant row: the coefficient is added without a product.
          cmd.op  = w2s_pkg::DP_ADDC;
          idx_nxt = idx_r + 4'd1;
          if (idx_r == 4'd15) begin
            k_nxt     = '0;
            state_nxt = ST_DIV_INIT;
          end
        end else begin
          cmd.op    = w2s_pkg::DP_MUL;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.op    = w2s_pkg::DP_ACC;
        idx_nxt   = idx_r + 4'd1;
        state_nxt = ST_MUL;
      end
      ST_DIV_INIT: begin
        cmd.op    = w2s_pkg::DP_DIV_INIT;
        step_nxt  = '0;
        state_nxt = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd.op   = w2s_pkg::DP_DIV_STEP;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd31) begin
          state_nxt = ST_DIV_END;
        end
      end
      ST_DIV_END: begin
        cmd.op = w2s_pkg::DP_DIV_END;
        k_nxt  = k_r + 2'd1;
        state_nxt = (k_r == 2'd2) ? ST_MAP_XM : ST_DIV_INIT;
      end
      ST_MAP_XM: begin
        cmd.op    = w2s_pkg::DP_MAP_XM;
        state_nxt = ST_MAP_XA;
      end
      ST_MAP_XA: begin
        cmd.op    = w2s_pkg::DP_MAP_XA;
        state_nxt = ST_MAP_YM;
      end
      ST_MAP_YM: begin
        cmd.op    = w2s_pkg::DP_MAP_YM;
        state_nxt = ST_MAP_YA;
      end
      ST_MAP_YA: begin
        cmd.op    = w2s_pkg::DP_MAP_YA;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = w2s_pkg::DP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      k_r         <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      k_r         <= k_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ sv/w2s_checker.sv @@
// Port-level checker for the world-to-screen projection block, with its bind.
module w2s_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [95:0]  out_tdata,
  input logic [1:0]   out_tuser
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_wzero_invisible: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0])
    else $error("zero w reported as visible");

  a_wzero_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      (out_tdata[95:64] == 32'h7fff_ffff) || (out_tdata[95:64] == 32'h8000_0000))
    else $error("zero w depth not saturated");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind world_to_screen_projection w2s_checker u_w2s_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
